// ----- rtl/cobs_pkg.sv -----
// Shared types and constants for the COBS frame decoder.
package cobs_pkg;

  // Largest data run of one block; a code of BLOCK_MAX + 1 leaves no implied zero.
  localparam int unsigned BLOCK_MAX = 254;
  localparam logic [7:0] CODE_NO_ZERO = 8'(BLOCK_MAX + 1);
  localparam logic [7:0] DELIMITER = 8'h00;

  // Decoupling queue between the classifier and the result emitter.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       buffer_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       frame_ok;
    logic       run_last;
  } out_item_t;

  // Kind of the first result an item causes.
  typedef enum logic [1:0] {
    OP_DATA,
    OP_ZERO,
    OP_END_OK,
    OP_END_FAIL
  } op_e;

  // One queued work entry: first result plus an optional trailing failure report.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       tail_fail;
  } entry_t;

endpackage

// ----- rtl/cobs_front.sv -----
// Front end: accepts encoded bytes, tracks block state and classifies each item.
module cobs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cobs_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cobs_pkg::entry_t   q_entry_o
);

  logic [7:0] bytes_left_q, bytes_left_d;
  logic       pending_zero_q, pending_zero_d;
  logic       skipping_q, skipping_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic first_valid;
    logic done;
    first_valid      = 1'b0;
    done             = 1'b0;
    bytes_left_d     = bytes_left_q;
    pending_zero_d   = pending_zero_q;
    skipping_d       = skipping_q;
    q_entry_o.op        = cobs_pkg::OP_DATA;
    q_entry_o.data      = in_data_i.in_byte;
    q_entry_o.tail_fail = 1'b0;

    if (skipping_q) begin
      if (in_data_i.buffer_last) begin
        skipping_d = 1'b0;
      end
    end else begin
      if (in_data_i.has_byte) begin
        if (bytes_left_q != 8'd0) begin
          first_valid  = 1'b1;
          q_entry_o.op = cobs_pkg::OP_DATA;
          bytes_left_d = bytes_left_q - 8'd1;
        end else if (in_data_i.in_byte == cobs_pkg::DELIMITER) begin
          first_valid    = 1'b1;
          done           = 1'b1;
          q_entry_o.op   = cobs_pkg::OP_END_OK;
          skipping_d     = 1'b1;
          pending_zero_d = 1'b0;
        end else begin
          // new code byte: the previous short block implies a zero
          if (pending_zero_q) begin
            first_valid  = 1'b1;
            q_entry_o.op = cobs_pkg::OP_ZERO;
          end
          bytes_left_d   = in_data_i.in_byte - 8'd1;
          pending_zero_d = in_data_i.in_byte < cobs_pkg::CODE_NO_ZERO;
        end
      end
      if (in_data_i.buffer_last) begin
        if (!done) begin
          if (first_valid) begin
            q_entry_o.tail_fail = 1'b1;
          end else begin
            first_valid  = 1'b1;
            q_entry_o.op = cobs_pkg::OP_END_FAIL;
          end
        end
        bytes_left_d   = 8'd0;
        pending_zero_d = 1'b0;
        skipping_d     = 1'b0;
      end
    end
    q_push_o = accept && first_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q   <= 8'd0;
      pending_zero_q <= 1'b0;
      skipping_q     <= 1'b0;
    end else if (accept) begin
      bytes_left_q   <= bytes_left_d;
      pending_zero_q <= pending_zero_d;
      skipping_q     <= skipping_d;
    end
  end

endmodule

// ----- rtl/cobs_fifo.sv -----
// Small entry queue between the front end and the result emitter.
module cobs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cobs_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cobs_pkg::entry_t head_o
);

  cobs_pkg::entry_t mem_q [cobs_pkg::QUEUE_DEPTH];
  logic [cobs_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cobs_pkg::QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == cobs_pkg::QUEUE_CNT_W'(cobs_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// ----- rtl/cobs_back.sv -----
// Back end: expands queued entries into result transfers through an output register.
module cobs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  cobs_pkg::entry_t    q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cobs_pkg::out_item_t out_data_o
);

  logic                phase_q, phase_d;   // 1: first result sent, failure report due
  logic                out_valid_q;
  cobs_pkg::out_item_t out_q, out_d;
  logic                load, emit;

  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && !q_empty_i;

  always_comb begin
    out_d = '0;
    if (phase_q) begin
      out_d.frame_end = 1'b1;
      out_d.run_last  = 1'b1;
    end else begin
      out_d.run_last = !q_head_i.tail_fail;
      unique case (q_head_i.op)
        cobs_pkg::OP_DATA:     out_d.out_byte = q_head_i.data;
        cobs_pkg::OP_ZERO:     out_d.out_byte = 8'd0;
        cobs_pkg::OP_END_OK: begin
          out_d.frame_end = 1'b1;
          out_d.frame_ok  = 1'b1;
        end
        cobs_pkg::OP_END_FAIL: out_d.frame_end = 1'b1;
        default:               out_d = '0;
      endcase
    end
    q_pop_o = emit && (phase_q || !q_head_i.tail_fail);
    phase_d = phase_q;
    if (emit) begin
      phase_d = phase_q ? 1'b0 : q_head_i.tail_fail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= emit;
      end
      phase_q <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_tail_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!q_empty_i && q_head_i.tail_fail))
    else $error("failure report due without a matching queue entry");

endmodule

// ----- rtl/cobs_frame_decoder.sv -----
// Top level of the streaming COBS frame decoder.
// COBS frame decoder. Each input transfer carries at most one encoded byte plus a
// buffer_last flag; each output transfer is either a decoded data byte or a frame
// end report (frame_ok 1 on the delimiter, 0 when the buffer ended without one, in
// which case the frame's data must be discarded). run_last marks the final output
// caused by one input. A front end tracks the block counter, the implied-zero mark
// and the skip-after-delimiter mark and classifies every input in the cycle it is
// accepted; a four-entry queue carries the classified work to a back end that
// drives a registered output. Inputs are taken one per clock while the queue has
// room; an input that causes two outputs (a byte followed by a failure report)
// holds the output side for both, so one input per clock is sustained as long as
// inputs average at most one output each and the output is not stalled, with at
// most one output per clock. Output valid rises once the input's entry has been
// written into the queue and then loaded into the output register. No clearing
// pass is needed after reset.
module cobs_frame_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cobs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cobs_pkg::out_item_t out_data_o
);

  logic             q_push, q_full, q_pop, q_empty;
  cobs_pkg::entry_t q_entry, q_head;

  // Classifier: owns all decoding state, pushes one entry per producing transfer.
  cobs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  cobs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Emitter: one output per clock while not stalled, second pass for the trailing failure report.
  cobs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
